// ===== rtl/core/b64d_pkg.sv =====
// Shared types, constants and helpers for the base64 stream decoder.
// No dependencies; imported by every module of the decoder.
package b64d_pkg;

   // Width of the internal saturating byte counter
   localparam int LENGTH_BITS = 24;
   // Width of the decoded length field on the result channel
   localparam int DLEN_W      = 24;
   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stop reasons as carried on the end marker
   localparam logic [1:0] STOP_NONE = 2'd0;
   localparam logic [1:0] STOP_PAD  = 2'd1;
   localparam logic [1:0] STOP_BAD  = 2'd2;

   // Result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Character classes
   typedef enum logic [1:0] {
      CC_ALPHA,
      CC_PAD,
      CC_BAD
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [5:0]     value;
   } sextet_type;

   // Three decoded bytes, index 0 is the first out
   typedef logic [2:0][7:0] bytes_type;

   // One unit of work passed from front to back
   typedef struct packed {
      logic [1:0]        n_bytes;
      bytes_type         bytes;
      logic              has_end;
      logic [DLEN_W-1:0] length;
      logic [1:0]        reason;
   } job_type;

   // Map one character onto its sextet and class
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r.cls   = CC_BAD;
      r.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r.cls   = CC_ALPHA;
         r.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         r.cls   = CC_ALPHA;
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.cls   = CC_ALPHA;
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         r.cls   = CC_ALPHA;
         r.value = 6'd62;
      end else if (c == 8'h2f) begin
         r.cls   = CC_ALPHA;
         r.value = 6'd63;
      end else if (c == 8'h3d) begin
         r.cls   = CC_PAD;
      end
      return r;
   endfunction

   // Four sextets to three bytes
   function automatic bytes_type decode4(input logic [5:0] s0, input logic [5:0] s1,
                                         input logic [5:0] s2, input logic [5:0] s3);
      bytes_type b;
      b[0] = {s0, s1[5:4]};
      b[1] = {s1[3:0], s2[5:2]};
      b[2] = {s2[1:0], s3};
      return b;
   endfunction

endpackage

// ===== rtl/core/b64d_front.sv =====
// Front end: takes characters, classifies them, keeps the group and count state
// and hands one job per productive character to the queue. Uses b64d_pkg.
module b64d_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] in_char
   input  logic             req_tlast,
   input  logic             q_full,
   output logic             q_push,
   output b64d_pkg::job_type q_job
);
   import b64d_pkg::*;

   logic [1:0]             gc_ff, gc_in;
   logic [17:0]            hold_ff, hold_in;
   logic [1:0]             stopped_ff, stopped_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;

   sextet_type             sx;
   logic                   accept;
   logic [1:0]             gc1;
   logic [17:0]            hold1;
   logic [1:0]             stop1;
   logic [1:0]             n_bytes;
   bytes_type              bytes;
   logic [LENGTH_BITS:0]   sum;
   logic [LENGTH_BITS-1:0] sat_total;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign sx         = sextet_of(req_tdata);

   // Group assembly, stop detection and the flush of a partial group
   always_comb begin
      gc1     = gc_ff;
      hold1   = hold_ff;
      stop1   = stopped_ff;
      n_bytes = 2'd0;
      bytes   = '0;
      if (stopped_ff == STOP_NONE) begin
         case (sx.cls)
            CC_PAD: stop1 = STOP_PAD;
            CC_BAD: stop1 = STOP_BAD;
            default: begin
               if (gc_ff == 2'd3) begin
                  bytes   = decode4(hold_ff[17:12], hold_ff[11:6], hold_ff[5:0], sx.value);
                  n_bytes = 2'd3;
                  gc1     = 2'd0;
                  hold1   = '0;
               end else begin
                  hold1 = {hold_ff[11:0], sx.value};
                  gc1   = gc_ff + 2'd1;
               end
            end
         endcase
      end
      // partial group zero-filled on the last word
      if (req_tlast && gc1 == 2'd2) begin
         bytes   = decode4(hold1[11:6], hold1[5:0], 6'd0, 6'd0);
         n_bytes = 2'd1;
      end else if (req_tlast && gc1 == 2'd3) begin
         bytes   = decode4(hold1[17:12], hold1[11:6], hold1[5:0], 6'd0);
         n_bytes = 2'd2;
      end
   end

   // Saturating byte count
   assign sum       = {1'b0, total_ff} + (LENGTH_BITS + 1)'(n_bytes);
   assign sat_total = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];

   // Job to the back end
   assign q_push         = accept && (n_bytes != 2'd0 || req_tlast);
   assign q_job.n_bytes  = n_bytes;
   assign q_job.bytes    = bytes;
   assign q_job.has_end  = req_tlast;
   assign q_job.length   = DLEN_W'(sat_total);
   assign q_job.reason   = stop1;

   // Next state: back to reset values after the last word
   always_comb begin
      gc_in      = gc_ff;
      hold_in    = hold_ff;
      stopped_in = stopped_ff;
      total_in   = total_ff;
      if (accept) begin
         if (req_tlast) begin
            gc_in      = 2'd0;
            hold_in    = '0;
            stopped_in = STOP_NONE;
            total_in   = '0;
         end else begin
            gc_in      = gc1;
            hold_in    = hold1;
            stopped_in = stop1;
            total_in   = sat_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff      <= 2'd0;
         hold_ff    <= '0;
         stopped_ff <= STOP_NONE;
         total_ff   <= '0;
      end else begin
         gc_ff      <= gc_in;
         hold_ff    <= hold_in;
         stopped_ff <= stopped_in;
         total_ff   <= total_in;
      end
   end

`ifndef ASSERT_OFF
   // message state is cleared after the last word
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> gc_ff == 2'd0 && stopped_ff == STOP_NONE && total_ff == '0)
      else $error("front state not cleared after last word");

   // a stop persists until the message ends
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff != STOP_NONE && !(accept && req_tlast) |=> stopped_ff == $past(stopped_ff))
      else $error("stop reason changed mid-message");
`endif

endmodule

// ===== rtl/core/b64d_queue.sv =====
// Short job queue between the front and back ends of the decoder.
// Uses b64d_pkg for the job type and depth.
module b64d_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  b64d_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output b64d_pkg::job_type pop_job
);
   import b64d_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_job   = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef ASSERT_OFF
   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");
`endif

endmodule

// ===== rtl/core/b64d_back.sv =====
// Back end: unpacks each job into data words and an end marker, one word a
// cycle, holding the current word until the receiver takes it. Uses b64d_pkg.
module b64d_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  b64d_pkg::job_type q_job,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] data_byte, [31:8] decoded_length,
                                         // [33:32] stop_reason, rest zero
   output logic             rsp_tuser,   // [0] kind
   output logic             rsp_tlast    // end_of_run
);
   import b64d_pkg::*;

   job_type     job_ff, job_in;
   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;

   logic [2:0]  total;
   logic        is_data;
   logic        is_last;
   logic        fire;
   logic        load;

   assign total   = {1'b0, job_ff.n_bytes} + {2'b00, job_ff.has_end};
   assign is_data = idx_ff < job_ff.n_bytes;
   assign is_last = {1'b0, idx_ff} == total - 3'd1;
   assign fire    = valid_ff && rsp_tready;
   assign load    = (!valid_ff || (fire && is_last)) && q_not_empty;
   assign q_pop   = load;

   // Word sequencing within a job
   always_comb begin
      job_in   = job_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         job_in   = q_job;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (fire && is_last) begin
         valid_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   // Result word fields
   assign rsp_tvalid        = valid_ff;
   assign rsp_tuser         = is_data ? KIND_DATA : KIND_END;
   assign rsp_tlast         = is_last;
   assign rsp_tdata[7:0]    = is_data ? job_ff.bytes[idx_ff] : 8'd0;
   assign rsp_tdata[31:8]   = is_data ? '0 : job_ff.length;
   assign rsp_tdata[33:32]  = is_data ? STOP_NONE : job_ff.reason;
   assign rsp_tdata[39:34]  = '0;

`ifndef ASSERT_OFF
   // a held job always has words left
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> total != 3'd0 && {1'b0, idx_ff} < total)
      else $error("word index beyond job");

   // the end marker only ever closes a job
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !is_data |-> is_last)
      else $error("end marker not last word of job");
`endif

endmodule

// ===== rtl/core/base64_stream_decoder.sv =====
// Base64 stream decoder: characters in on the req_ channel, one per word with
// tlast closing a message; decoded bytes and an end marker out on rsp_.
// rsp_tuser is the kind (0 data byte, 1 end marker); rsp_tlast marks the last
// word caused by one input character. The end marker carries the message's
// saturating byte count and the stop reason ('=' or an invalid character).
// A character is taken every cycle while the two-entry job queue has room.
// A job passes through a queue slot and then the output register before its
// first result word leaves.
// The output side sends one word a cycle while the receiver is ready, so a character
// completing a group occupies it for three words, or four on a final character with a marker;
// that single result port sets the sustained rate.
// If the receiver stalls, the output word holds, the queue fills and req_tready
// falls until room frees up.
// Reset (synchronous, active high) empties the queue and clears the group,
// stop and count state; no clearing pass is needed.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
module base64_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] data_byte, [31:8] decoded_length,
                                    // [33:32] stop_reason, rest zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // end_of_run
);
   import b64d_pkg::*;

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_not_empty;
   job_type push_job;
   job_type pop_job;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_job   (pop_job)
   );

   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for base64_stream_decoder: directed table, then random messages.
// Expected words come from an in-bench decoder model; uses b64d_pkg types and codes.
// Needs only rtl/core/b64d_pkg.sv and the decoder RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   // Sextet lookup outcomes other than a value
   localparam int SX_PAD = -1;
   localparam int SX_BAD = -2;
   // Idle-cycle watchdog and long receiver hold-off
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD   = 150;

   // One result word as the checker sees it
   typedef struct packed {
      logic              kind;
      logic [7:0]        dbyte;
      logic [DLEN_W-1:0] dlen;
      logic [1:0]        why;
      logic              eor;
   } rsp_word_type;

   // One row of the directed table; n_typed > 0 means the words are written out
   typedef struct {
      logic [7:0]   ch;
      logic         lst;
      int           n_typed;
      rsp_word_type t0;
      rsp_word_type t1;
   } stim_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] in_char
   logic        req_tlast  = 1'b0;   // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [7:0] data_byte, [31:8] decoded_length,
                                     // [33:32] stop_reason
   logic        rsp_tuser;           // [0] kind
   logic        rsp_tlast;           // end_of_run

   base64_stream_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Decoder model state
   logic [1:0]             held_n   = 2'd0;
   logic [17:0]            held     = 18'd0;
   logic [1:0]             halt     = STOP_NONE;
   logic [LENGTH_BITS-1:0] byte_cnt = '0;

   rsp_word_type  fresh_words[$];   // words caused by the character just taken
   rsp_word_type  pending_words[$]; // words still owed by the decoder
   stim_row_type  dir_tab[$];
   int         err_cnt     = 0;
   int         chars_sent  = 0;
   int         tx_idle_pct = 0;
   int         rx_idle_pct = 0;
   int         hold_asked  = 0;
   int         hold_granted = 0;
   int         hold_left   = 0;
   int         quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // --------------------------------------------------------------------
   // Decoder model
   // --------------------------------------------------------------------
   function automatic int sextet_code(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return int'(ch) - 65;
      if (ch >= "a" && ch <= "z") return int'(ch) - 97 + 26;
      if (ch >= "0" && ch <= "9") return int'(ch) - 48 + 52;
      if (ch == "+") return 62;
      if (ch == "/") return 63;
      if (ch == "=") return SX_PAD;
      return SX_BAD;
   endfunction

   function automatic rsp_word_type data_word(input logic [7:0] b, input logic eor);
      rsp_word_type w;
      w       = '0;
      w.kind  = KIND_DATA;
      w.dbyte = b;
      w.eor   = eor;
      return w;
   endfunction

   function automatic rsp_word_type end_word(input logic [DLEN_W-1:0] len,
                                             input logic [1:0] why);
      rsp_word_type w;
      w      = '0;
      w.kind = KIND_END;
      w.dlen = len;
      w.why  = why;
      w.eor  = 1'b1;
      return w;
   endfunction

   // Emit one decoded byte and bump the saturating count
   task automatic emit_byte(input logic [7:0] b);
      fresh_words.push_back(data_word(b, 1'b0));
      if (byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
   endtask

   // Advance the model by one character; results land in fresh_words
   task automatic decode_char(input logic [7:0] ch, input logic lst);
      int          sx;
      logic [23:0] grp;
      fresh_words.delete();
      if (halt == STOP_NONE) begin
         sx = sextet_code(ch);
         if (sx == SX_PAD) begin
            halt = STOP_PAD;
         end else if (sx == SX_BAD) begin
            halt = STOP_BAD;
         end else if (held_n == 2'd3) begin
            grp = {held, 6'(sx)};
            emit_byte(grp[23:16]);
            emit_byte(grp[15:8]);
            emit_byte(grp[7:0]);
            held_n = 2'd0;
            held   = '0;
         end else begin
            held   = {held[11:0], 6'(sx)};
            held_n = held_n + 2'd1;
         end
      end
      if (lst) begin
         // zero-fill a partial group; a lone sextet is dropped
         if (held_n == 2'd2) begin
            grp = {held[11:0], 12'd0};
            emit_byte(grp[23:16]);
         end else if (held_n == 2'd3) begin
            grp = {held, 6'd0};
            emit_byte(grp[23:16]);
            emit_byte(grp[15:8]);
         end
         fresh_words.push_back(end_word(DLEN_W'(byte_cnt), halt));
         held_n   = 2'd0;
         held     = '0;
         halt     = STOP_NONE;
         byte_cnt = '0;
      end
      if (fresh_words.size() != 0) fresh_words[fresh_words.size() - 1].eor = 1'b1;
   endtask

   // --------------------------------------------------------------------
   // Sender: offer one character, wait for the handshake, log expectations
   // --------------------------------------------------------------------
   task automatic send_char(input logic [7:0] ch, input logic lst, input int n_typed,
                            input rsp_word_type t0, input rsp_word_type t1);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      decode_char(ch, lst);
      if (n_typed == 0) begin
         foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
      end else begin
         pending_words.push_back(t0);
         if (n_typed > 1) pending_words.push_back(t1);
      end
   endtask

   // Sender pauses until every owed word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] b64_char(input int idx);
      if (idx < 26) return 8'(65 + idx);
      if (idx < 52) return 8'(97 + idx - 26);
      if (idx < 62) return 8'(48 + idx - 52);
      if (idx == 62) return "+";
      return "/";
   endfunction

   function automatic logic [7:0] bad_char();
      logic [7:0] ch;
      do ch = 8'($urandom_range(255)); while (sextet_code(ch) != SX_BAD);
      return ch;
   endfunction

   // One random message: mostly clean text, some padded, some with bad or noisy bytes
   task automatic send_message(input int max_groups);
      logic [7:0] txt[$];
      int         groups;
      int         tail;
      int         style;
      groups = $urandom_range(max_groups, 0);
      tail   = $urandom_range(3);
      style  = $urandom_range(9);
      repeat (groups * 4 + tail) txt.push_back(b64_char($urandom_range(63)));
      if (style == 6 || style == 7) begin
         txt.push_back("=");
         if (tail == 2 || style == 7) txt.push_back("=");
      end else if (style == 8) begin
         txt.insert($urandom_range(txt.size()), bad_char());
      end else if (style == 9) begin
         foreach (txt[i]) if ($urandom_range(3) == 0) txt[i] = 8'($urandom_range(255));
      end
      // trailing bytes after a stop should be ignored
      if (style >= 6) repeat ($urandom_range(2)) txt.push_back(8'($urandom_range(255)));
      if (txt.size() == 0) txt.push_back(b64_char($urandom_range(63)));
      foreach (txt[i]) send_char(txt[i], i == txt.size() - 1, 0, '0, '0);
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int n_chars);
      int stop_at;
      tx_idle_pct = tx_pct;
      rx_idle_pct <= rx_pct;
      stop_at = chars_sent + n_chars;
      while (chars_sent < stop_at) send_message(($urandom_range(19) == 0) ? 15 : 3);
      wait_drained();
   endtask

   task automatic add_row(input logic [7:0] ch, input logic lst, input int n_typed,
                          input rsp_word_type t0, input rsp_word_type t1);
      stim_row_type r;
      r.ch      = ch;
      r.lst     = lst;
      r.n_typed = n_typed;
      r.t0      = t0;
      r.t1      = t1;
      dir_tab.push_back(r);
   endtask

   // --------------------------------------------------------------------
   // Receiver: random ready, with one long hold-off on request
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_asked != hold_granted) begin
         hold_granted <= hold_asked;
         hold_left    <= LONG_HOLD;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("MISMATCH %s: got %0h want %0h", what, got, want);
      err_cnt++;
   endtask

   // Checker: each word against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            flag_mismatch("word with nothing owed", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_tuser !== want.kind)
               flag_mismatch("kind", 32'(rsp_tuser), 32'(want.kind));
            if (rsp_tdata[7:0] !== want.dbyte)
               flag_mismatch("data_byte", 32'(rsp_tdata[7:0]), 32'(want.dbyte));
            if (rsp_tdata[31:8] !== want.dlen)
               flag_mismatch("decoded_length", 32'(rsp_tdata[31:8]), 32'(want.dlen));
            if (rsp_tdata[33:32] !== want.why)
               flag_mismatch("stop_reason", 32'(rsp_tdata[33:32]), 32'(want.why));
            if (rsp_tlast !== want.eor)
               flag_mismatch("end_of_run", 32'(rsp_tlast), 32'(want.eor));
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------
   initial begin
      // single-character messages: lone sextet, pad, bad bytes at both ends of the range
      add_row("A",   1'b1, 1, end_word('0, STOP_NONE), '0);
      add_row("=",   1'b1, 1, end_word('0, STOP_PAD), '0);
      add_row(8'hff, 1'b1, 1, end_word('0, STOP_BAD), '0);
      add_row(8'h00, 1'b1, 1, end_word('0, STOP_BAD), '0);
      // two sextets flushed into one byte
      add_row("Q",   1'b0, 0, '0, '0);
      add_row("Q",   1'b1, 2, data_word(8'h41, 1'b0), end_word(DLEN_W'(1), STOP_NONE));
      // full group of all ones, then three sextets flushed into two bytes
      add_row("/",   1'b0, 0, '0, '0);
      add_row("/",   1'b0, 0, '0, '0);
      add_row("/",   1'b0, 0, '0, '0);
      add_row("/",   1'b0, 0, '0, '0);
      add_row("+",   1'b0, 0, '0, '0);
      add_row("+",   1'b0, 0, '0, '0);
      add_row("+",   1'b1, 0, '0, '0);
      // full group completed by the last character
      add_row("T",   1'b0, 0, '0, '0);
      add_row("W",   1'b0, 0, '0, '0);
      add_row("F",   1'b0, 0, '0, '0);
      add_row("u",   1'b1, 0, '0, '0);
      // stop at pad with a partial group held, junk after it ignored
      add_row("A",   1'b0, 0, '0, '0);
      add_row("B",   1'b0, 0, '0, '0);
      add_row("=",   1'b0, 0, '0, '0);
      add_row("x",   1'b0, 0, '0, '0);
      add_row(8'hc3, 1'b1, 0, '0, '0);
      // last character itself invalid, partial group still flushed
      add_row("z",   1'b0, 0, '0, '0);
      add_row("9",   1'b0, 0, '0, '0);
      add_row("!",   1'b1, 0, '0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_char(dir_tab[i].ch, dir_tab[i].lst, dir_tab[i].n_typed,
                   dir_tab[i].t0, dir_tab[i].t1);
      wait_drained();

      run_phase(10, 78, 170);
      run_phase(78, 10, 170);

      // receiver holds off while a long message is offered, so the input stalls
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      hold_asked  <= hold_asked + 1;
      send_message(6);
      run_phase(0, 0, 140);

      repeat (10) @(posedge clock);
      if (err_cnt == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
